/* src/snm_pkg.sv */
// Shared types and constants for the Sobel height-to-normal-map block.
// No dependencies; imported by every module of the block.
package snm_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 12;
  localparam int SLOT_W    = 2;
  localparam int ADDR_W    = SLOT_W + COL_W;
  localparam int ROW_DEPTH = 3 * MAX_WIDTH;
  localparam int VEC_W     = 12;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = 2;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_Z      = 2'd2;

  // Input item kinds
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  // Gradient request passed from the front to the normalizer
  typedef struct packed {
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic                    done;
  } pix_req_t;

  // Line-store position of one output pixel
  typedef struct packed {
    logic [SLOT_W-1:0] slot_t;
    logic [SLOT_W-1:0] slot_m;
    logic [SLOT_W-1:0] slot_b;
    logic [COL_W-1:0]  col;
    logic              done;
  } pix_pos_t;

  // Previous slot of the three-row circular store
  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    slot_dec = (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage

/* src/sobel_height_to_normal_map.sv */
// Sobel normal map: the front end accepts a sample, then for each output pixel
// it makes nine line-store reads, captures the window and pushes the gradient.
// A sample gives no, one or two pixels; the next is taken once they are pushed.
// The normalizer forms 17 quotient bits per result, one result at a time.
// Reset (rst_n, synchronous, active low) clears positions, queue and output;
// registers return to 256, 256, 255. The line store is not cleared.
module sobel_height_to_normal_map import snm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // height_sample
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // normal_red, normal_green, normal_blue
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  logic [11:0]      width_r;
  logic [12:0]      height_r;
  logic [9:0]       z_r;
  logic             restart;
  logic [11:0]      eff_w;
  logic [12:0]      eff_h;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;
  logic [9:0]       z_eff;
  logic             q_push, q_pop, q_full, q_empty;
  pix_req_t         q_din, q_dout;

  assign restart = cfg_wr_en &&
                   (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT || cfg_index == CFG_Z);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd256;
      height_r <= 13'd256;
      z_r      <= 10'd255;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata[11:0];
        CFG_HEIGHT: height_r <= cfg_wdata;
        CFG_Z:      z_r      <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the frame size and z term
  always_comb begin
    if (width_r == '0) eff_w = 12'd1;
    else if (width_r > 12'(MAX_WIDTH)) eff_w = 12'(MAX_WIDTH);
    else eff_w = width_r;
    if (height_r == '0) eff_h = 13'd1;
    else if (height_r > 13'd4096) eff_h = 13'd4096;
    else eff_h = height_r;
    wm1   = COL_W'(eff_w - 12'd1);
    hm1   = ROW_W'(eff_h - 13'd1);
    z_eff = (z_r == '0) ? 10'd1 : z_r;
  end

  snm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .wm1       (wm1),
    .hm1       (hm1),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_din     (q_din),
    .q_full    (q_full)
  );

  snm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  snm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .z_eff      (z_eff),
    .q_dout     (q_dout),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Queue must never be overrun or underrun
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("request queue underflow");

endmodule

/* src/snm_front.sv */
// Front end: accepts samples and drain requests, keeps the raster position,
// owns the three-row line store and gathers each 3x3 window. Uses snm_pkg.
module snm_front import snm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  logic [COL_W-1:0] wm1,
  input  logic [ROW_W-1:0] hm1,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tuser,
  output logic             q_push,
  output pix_req_t         q_din,
  input  logic             q_full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_READ = 4'b0010,
    F_LAST = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [COL_W-1:0]  drain_col_r, drain_col_nxt;
  logic              frame_full_r, frame_full_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  pix_pos_t          cur_r, cur_nxt;
  pix_pos_t          pend_r, pend_nxt;
  logic              has_pend_r, has_pend_nxt;
  logic [3:0]        tap_r, tap_nxt;

  logic [7:0]        mem [0:ROW_DEPTH-1];
  logic [7:0]        rd_q_r;
  logic [3:0]        rd_tap_r;
  logic              rd_vld_r;
  logic [7:0]        window_r [0:8];

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [SLOT_W-1:0] sm1, sm2;
  logic              has_a, has_b;
  pix_pos_t          pos_a, pos_b, pos_d;
  logic [SLOT_W-1:0] rd_slot;
  logic [COL_W-1:0]  rd_col, col_l, col_r;

  assign in_tready = (state_r == F_IDLE);
  assign sm1       = slot_dec(slot_r);
  assign sm2       = slot_dec(sm1);
  assign wr_addr   = {slot_r, in_col_r};

  // Candidate pixels for the current sample and for a drain request
  always_comb begin
    has_a        = (in_row_r != '0) && (in_col_r != '0);
    has_b        = (in_row_r != '0) && (in_col_r == wm1);
    pos_a.slot_t = (in_row_r == ROW_W'(1)) ? sm1 : sm2;
    pos_a.slot_m = sm1;
    pos_a.slot_b = slot_r;
    pos_a.col    = in_col_r - COL_W'(1);
    pos_a.done   = 1'b0;
    pos_b        = pos_a;
    pos_b.col    = wm1;
    pos_d.slot_t = (in_row_r == '0) ? slot_r : sm1;
    pos_d.slot_m = slot_r;
    pos_d.slot_b = slot_r;
    pos_d.col    = drain_col_r;
    pos_d.done   = (drain_col_r >= wm1);
  end

  // Sequencer: accept, read nine taps, push the gradient
  always_comb begin
    state_nxt      = state_r;
    in_row_nxt     = in_row_r;
    in_col_nxt     = in_col_r;
    drain_col_nxt  = drain_col_r;
    frame_full_nxt = frame_full_r;
    slot_nxt       = slot_r;
    cur_nxt        = cur_r;
    pend_nxt       = pend_r;
    has_pend_nxt   = has_pend_r;
    tap_nxt        = tap_r;
    wr_en          = 1'b0;
    q_push         = 1'b0;
    if (restart) begin
      state_nxt      = F_IDLE;
      in_row_nxt     = '0;
      in_col_nxt     = '0;
      drain_col_nxt  = '0;
      frame_full_nxt = 1'b0;
      slot_nxt       = '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_tvalid) begin
            if (in_tuser == ACT_SAMPLE) begin
              if (!frame_full_r) begin
                wr_en   = 1'b1;
                tap_nxt = '0;
                if (has_a) begin
                  cur_nxt      = pos_a;
                  pend_nxt     = pos_b;
                  has_pend_nxt = has_b;
                  state_nxt    = F_READ;
                end else if (has_b) begin
                  cur_nxt      = pos_b;
                  has_pend_nxt = 1'b0;
                  state_nxt    = F_READ;
                end
                if (in_col_r >= wm1) begin
                  in_col_nxt = '0;
                  if (in_row_r >= hm1) begin
                    frame_full_nxt = 1'b1;
                  end else begin
                    in_row_nxt = in_row_r + ROW_W'(1);
                    slot_nxt   = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
                  end
                end else begin
                  in_col_nxt = in_col_r + COL_W'(1);
                end
              end
            end else if (frame_full_r) begin
              cur_nxt      = pos_d;
              has_pend_nxt = 1'b0;
              tap_nxt      = '0;
              state_nxt    = F_READ;
              if (pos_d.done) begin
                in_row_nxt     = '0;
                in_col_nxt     = '0;
                drain_col_nxt  = '0;
                frame_full_nxt = 1'b0;
                slot_nxt       = '0;
              end else begin
                drain_col_nxt = drain_col_r + COL_W'(1);
              end
            end
          end
        end
        F_READ: begin
          tap_nxt = tap_r + 4'd1;
          if (tap_r == 4'd8) begin
            tap_nxt   = '0;
            state_nxt = F_LAST;
          end
        end
        F_LAST: begin
          state_nxt = F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            q_push = 1'b1;
            if (has_pend_r) begin
              cur_nxt      = pend_r;
              has_pend_nxt = 1'b0;
              state_nxt    = F_READ;
            end else begin
              state_nxt = F_IDLE;
            end
          end
        end
        default: state_nxt = F_IDLE;
      endcase
    end
  end

  // Tap address: rows top/mid/bottom, columns clamped at the edges
  always_comb begin
    col_l = (cur_r.col == '0) ? '0 : cur_r.col - COL_W'(1);
    col_r = (cur_r.col == wm1) ? cur_r.col : cur_r.col + COL_W'(1);
    unique case (tap_r)
      4'd0: begin rd_slot = cur_r.slot_t; rd_col = col_l;     end
      4'd1: begin rd_slot = cur_r.slot_t; rd_col = cur_r.col; end
      4'd2: begin rd_slot = cur_r.slot_t; rd_col = col_r;     end
      4'd3: begin rd_slot = cur_r.slot_m; rd_col = col_l;     end
      4'd4: begin rd_slot = cur_r.slot_m; rd_col = cur_r.col; end
      4'd5: begin rd_slot = cur_r.slot_m; rd_col = col_r;     end
      4'd6: begin rd_slot = cur_r.slot_b; rd_col = col_l;     end
      4'd7: begin rd_slot = cur_r.slot_b; rd_col = cur_r.col; end
      4'd8: begin rd_slot = cur_r.slot_b; rd_col = col_r;     end
      default: begin rd_slot = cur_r.slot_b; rd_col = col_r;  end
    endcase
    rd_addr = {rd_slot, rd_col};
  end

  // Line store: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_tdata;
    end
    rd_q_r   <= mem[rd_addr];
    rd_tap_r <= tap_r;
  end

  // Capture read data into the window
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      window_r[rd_tap_r] <= rd_q_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      in_row_r     <= '0;
      in_col_r     <= '0;
      drain_col_r  <= '0;
      frame_full_r <= 1'b0;
      slot_r       <= '0;
      has_pend_r   <= 1'b0;
      tap_r        <= '0;
      rd_vld_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_row_r     <= in_row_nxt;
      in_col_r     <= in_col_nxt;
      drain_col_r  <= drain_col_nxt;
      frame_full_r <= frame_full_nxt;
      slot_r       <= slot_nxt;
      has_pend_r   <= has_pend_nxt;
      tap_r        <= tap_nxt;
      rd_vld_r     <= (state_r == F_READ);
    end
  end

  // Pixel positions
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
  end

  // Sobel gradient from the captured window
  logic [9:0]         gx_p, gx_n, gy_p, gy_n;
  logic signed [12:0] dx, dy;

  always_comb begin
    gx_p = {2'b0, window_r[2]} + {1'b0, window_r[5], 1'b0} + {2'b0, window_r[8]};
    gx_n = {2'b0, window_r[0]} + {1'b0, window_r[3], 1'b0} + {2'b0, window_r[6]};
    gy_p = {2'b0, window_r[6]} + {1'b0, window_r[7], 1'b0} + {2'b0, window_r[8]};
    gy_n = {2'b0, window_r[0]} + {1'b0, window_r[1], 1'b0} + {2'b0, window_r[2]};
    dx   = signed'({3'b0, gx_p}) - signed'({3'b0, gx_n});
    dy   = signed'({3'b0, gy_p}) - signed'({3'b0, gy_n});
    q_din.vx   = signed'({dx[10:0], 1'b0});
    q_din.vy   = signed'({dy[10:0], 1'b0});
    q_din.done = cur_r.done;
  end

endmodule

/* src/snm_fifo.sv */
// Short request queue between the window front end and the normalizer.
// Uses snm_pkg for the request type and depth.
module snm_fifo import snm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pix_req_t din,
  output logic     full,
  input  logic     pop,
  output pix_req_t dout,
  output logic     empty
);

  pix_req_t          buf_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0]   wp_r, rp_r;
  logic [Q_AW:0]     cnt_r;

  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = buf_r[rp_r];

  // Store the request
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= din;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + Q_AW'(1);
      if (pop)  rp_r <= rp_r + Q_AW'(1);
      cnt_r <= cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

endmodule

/* src/snm_back.sv */
// Back end: normalizes each gradient vector one result bit per cycle and
// maps the components to bytes into an output register. Uses snm_pkg.
module snm_back import snm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [9:0]  z_eff,
  input  pix_req_t    q_dout,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SQ   = 5'b00010,
    B_SUM  = 5'b00100,
    B_ITER = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_t;

  bstate_t     state_r, state_nxt;
  logic [10:0] mag_r [0:2];
  logic [2:0]  neg_r;
  logic        done_r;
  logic [21:0] sq_r [0:2];
  logic [59:0] p_r [0:2];
  logic [59:0] rr_r [0:2];
  logic [16:0] q_r [0:2];
  logic [55:0] s2b_r;
  logic [16:0] bit_r;
  logic [4:0]  cnt_r;
  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic        out_last_r;

  logic        out_load;
  logic [23:0] s_sum;
  logic [59:0] p_try [0:2];
  logic        take [0:2];
  logic [17:0] biased [0:2];
  logic [25:0] scaled [0:2];
  logic [7:0]  byte_v [0:2];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign out_load   = (state_r == B_OUT) && (!out_valid_r || out_tready);
  assign s_sum      = {2'b0, sq_r[0]} + {2'b0, sq_r[1]} + {2'b0, sq_r[2]};

  // One trial bit per component: (q+b)^2*s against v^2 * 2^32
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_try[i] = p_r[i] + rr_r[i] + {4'b0, s2b_r};
      take[i]  = (p_try[i] <= {6'b0, sq_r[i], 32'b0});
    end
  end

  // Map Q1.16 components to bytes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      biased[i] = neg_r[i] ? 18'd65536 - {1'b0, q_r[i]}
                           : 18'd65536 + {1'b0, q_r[i]};
      scaled[i] = {biased[i], 8'b0} - {8'b0, biased[i]};
      byte_v[i] = scaled[i][24:17];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_SQ;
      B_SQ:   state_nxt = B_SUM;
      B_SUM:  state_nxt = B_ITER;
      B_ITER: if (cnt_r == 5'd16) state_nxt = B_OUT;
      B_OUT:  if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        neg_r[0] <= q_dout.vx[VEC_W-1];
        neg_r[1] <= q_dout.vy[VEC_W-1];
        neg_r[2] <= 1'b0;
        mag_r[0] <= q_dout.vx[VEC_W-1] ? 11'(~q_dout.vx + 12'd1) : q_dout.vx[10:0];
        mag_r[1] <= q_dout.vy[VEC_W-1] ? 11'(~q_dout.vy + 12'd1) : q_dout.vy[10:0];
        mag_r[2] <= {1'b0, z_eff};
        done_r   <= q_dout.done;
      end
      B_SQ: begin
        for (int i = 0; i < 3; i++) sq_r[i] <= 22'(mag_r[i]) * 22'(mag_r[i]);
      end
      B_SUM: begin
        for (int i = 0; i < 3; i++) begin
          p_r[i]  <= '0;
          rr_r[i] <= '0;
          q_r[i]  <= '0;
        end
        s2b_r <= {s_sum, 32'b0};
        bit_r <= 17'h10000;
        cnt_r <= '0;
      end
      B_ITER: begin
        for (int i = 0; i < 3; i++) begin
          if (take[i]) begin
            p_r[i]  <= p_try[i];
            q_r[i]  <= q_r[i] | bit_r;
            rr_r[i] <= (rr_r[i] >> 1) + {4'b0, s2b_r};
          end else begin
            rr_r[i] <= rr_r[i] >> 1;
          end
        end
        s2b_r <= s2b_r >> 2;
        bit_r <= bit_r >> 1;
        cnt_r <= cnt_r + 5'd1;
      end
      B_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {byte_v[2], byte_v[1], byte_v[0]};
      out_last_r <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
